// ===== hdl/rll_pkg.sv =====
`default_nettype none

package rll_pkg;

  // Width of the retry, timeout and ping tick counters
  localparam int TICK_COUNT_BITS = 16;
  // Width of the period registers
  localparam int PERIOD_W = 16;
  // Compare width that holds both a counter and a period register
  localparam int CMP_W = (TICK_COUNT_BITS > PERIOD_W) ? TICK_COUNT_BITS : PERIOD_W;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam int SALT_W = 32;

  // Register reset values
  localparam logic [PERIOD_W-1:0] RETRY_RESET   = PERIOD_W'(5000);
  localparam logic [PERIOD_W-1:0] TIMEOUT_RESET = PERIOD_W'(60000);
  localparam logic [PERIOD_W-1:0] PING_RESET    = PERIOD_W'(5000);

  typedef logic [TICK_COUNT_BITS-1:0] tick_count_t;

  typedef enum logic [2:0] {
    ST_DISC     = 3'd0,
    ST_WLOGIN   = 3'd1,
    ST_WAUTH    = 3'd2,
    ST_WCONFIG  = 3'd3,
    ST_WOPTIONS = 3'd4,
    ST_RUN      = 3'd5
  } link_state_t;

  typedef enum logic [2:0] {
    SEND_NONE    = 3'd0,
    SEND_LOGIN   = 3'd1,
    SEND_AUTH    = 3'd2,
    SEND_CONFIG  = 3'd3,
    SEND_OPTIONS = 3'd4,
    SEND_PING    = 3'd5
  } send_code_t;

  typedef enum logic [2:0] {
    MSG_ACK    = 3'd0,
    MSG_BEACON = 3'd1,
    MSG_PONG   = 3'd2,
    MSG_NAK    = 3'd3,
    MSG_CLOSE  = 3'd4,
    MSG_DATA   = 3'd5,
    MSG_OTHER  = 3'd6
  } msg_type_t;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_MSG  = 1'b1
  } kind_t;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_RETRY   = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_PING    = 2'd2,
    REG_OPTIONS = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              kind;
    logic [2:0]        msg_type;
    logic              ack_long;
    logic [SALT_W-1:0] salt_in;
  } evt_item_t;

  typedef struct packed {
    logic [2:0]        send_code;
    logic              deliver_data;
    logic [2:0]        link_state;
    logic [SALT_W-1:0] salt_out;
  } res_item_t;

  // Saturating increment of a tick counter
  function automatic tick_count_t bump(input tick_count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Period due: counter strictly above the register
  function automatic logic due(input tick_count_t c, input logic [PERIOD_W-1:0] p);
    return CMP_W'(c) > CMP_W'(p);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/repeater_login_link_fsm.sv =====
`default_nettype none

// Client-side repeater login/keepalive link controller. Each evt item is
// either one time tick or one classified received message; each yields
// exactly one res item carrying the message to send now, the data-deliver
// flag, the link state after the item and the stored login salt. An item
// passes an input register and one pass of state-update logic into the
// result register, and one item is taken every cycle while res is not
// stalled. The period registers (retry, timeout,
// ping, options_present) sit behind an APB port at byte addresses 0, 4, 8
// and 12; change them only while no item is in flight.
module repeater_login_link_fsm
  import rll_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // event channel
  input  wire logic              evt_valid,
  output      logic              evt_stall,
  input  wire evt_item_t         evt,
  // result channel
  output      logic              res_valid,
  input  wire logic              res_stall,
  output      res_item_t         res,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready
);

  // Configuration registers
  logic [PERIOD_W-1:0] retry_ticks;
  logic [PERIOD_W-1:0] timeout_ticks;
  logic [PERIOD_W-1:0] ping_ticks;
  logic                options_present;

  // Link state and counters
  link_state_t link_state, link_state_next;
  tick_count_t retry_count, retry_count_next;
  tick_count_t timeout_count, timeout_count_next;
  tick_count_t ping_count, ping_count_next;
  logic [SALT_W-1:0] salt_store, salt_store_next;

  // Pipeline
  logic        evt_q_valid;
  evt_item_t   evt_q;
  logic        advance;
  send_code_t  send;
  logic        deliver;

  tick_count_t retry_b, timeout_b, ping_b;
  cfg_reg_t    cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_t'(paddr[3:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_ticks     <= RETRY_RESET;
      timeout_ticks   <= TIMEOUT_RESET;
      ping_ticks      <= PING_RESET;
      options_present <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (cfg_sel)
        REG_RETRY:   retry_ticks     <= pwdata[PERIOD_W-1:0];
        REG_TIMEOUT: timeout_ticks   <= pwdata[PERIOD_W-1:0];
        REG_PING:    ping_ticks      <= pwdata[PERIOD_W-1:0];
        REG_OPTIONS: options_present <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (cfg_sel)
      REG_RETRY:   prdata = {{(DATA_W-PERIOD_W){1'b0}}, retry_ticks};
      REG_TIMEOUT: prdata = {{(DATA_W-PERIOD_W){1'b0}}, timeout_ticks};
      REG_PING:    prdata = {{(DATA_W-PERIOD_W){1'b0}}, ping_ticks};
      REG_OPTIONS: prdata = {{(DATA_W-1){1'b0}}, options_present};
      default:     prdata = '0;
    endcase
  end

  // Handshake: the input register moves on when the result register is free
  assign advance   = evt_q_valid && (!res_valid || !res_stall);
  assign evt_stall = evt_q_valid && res_valid && res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_q_valid <= 1'b0;
    end else begin
      evt_q_valid <= (evt_valid && !evt_stall) || (evt_q_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      evt_q <= evt;
    end
  end

  // Next link state, counters and message to send
  always_comb begin
    link_state_next    = link_state;
    retry_count_next   = retry_count;
    timeout_count_next = timeout_count;
    ping_count_next    = ping_count;
    salt_store_next    = salt_store;
    send               = SEND_NONE;
    deliver            = 1'b0;
    retry_b            = bump(retry_count);
    timeout_b          = bump(timeout_count);
    ping_b             = bump(ping_count);

    if (evt_q.kind == KIND_TICK) begin
      retry_count_next   = retry_b;
      timeout_count_next = timeout_b;
      ping_count_next    = ping_b;
      unique case (link_state)
        ST_DISC: begin
          if (due(retry_b, retry_ticks)) begin
            send               = SEND_LOGIN;
            link_state_next    = ST_WLOGIN;
            retry_count_next   = '0;
            timeout_count_next = '0;
          end
        end
        ST_RUN: begin
          if (due(ping_b, ping_ticks)) begin
            send            = SEND_PING;
            ping_count_next = '0;
          end
          if (due(timeout_b, timeout_ticks)) begin
            link_state_next  = ST_DISC;
            retry_count_next = '0;
          end
        end
        default: begin
          // waiting states: resend on retry, give up on timeout
          if (due(retry_b, retry_ticks)) begin
            unique case (link_state)
              ST_WLOGIN:  send = SEND_LOGIN;
              ST_WAUTH:   send = SEND_AUTH;
              ST_WCONFIG: send = SEND_CONFIG;
              default:    send = options_present ? SEND_OPTIONS : SEND_NONE;
            endcase
            retry_count_next = '0;
          end
          if (due(timeout_b, timeout_ticks)) begin
            link_state_next  = ST_DISC;
            retry_count_next = '0;
          end
        end
      endcase
    end else begin
      unique case (evt_q.msg_type)
        MSG_ACK: begin
          unique case (link_state)
            ST_WLOGIN: begin
              // short ack carries no salt and is dropped
              if (evt_q.ack_long) begin
                salt_store_next    = evt_q.salt_in;
                send               = SEND_AUTH;
                link_state_next    = ST_WAUTH;
                timeout_count_next = '0;
                retry_count_next   = '0;
              end
            end
            ST_WAUTH: begin
              send               = SEND_CONFIG;
              link_state_next    = ST_WCONFIG;
              timeout_count_next = '0;
              retry_count_next   = '0;
            end
            ST_WCONFIG: begin
              if (options_present) begin
                send            = SEND_OPTIONS;
                link_state_next = ST_WOPTIONS;
              end else begin
                link_state_next = ST_RUN;
              end
              timeout_count_next = '0;
              retry_count_next   = '0;
              ping_count_next    = '0;
            end
            ST_WOPTIONS: begin
              link_state_next    = ST_RUN;
              timeout_count_next = '0;
              ping_count_next    = '0;
            end
            default: ;
          endcase
        end
        MSG_BEACON: begin
          if (link_state == ST_WOPTIONS || link_state == ST_WCONFIG) begin
            link_state_next    = ST_RUN;
            timeout_count_next = '0;
            ping_count_next    = '0;
          end
        end
        MSG_PONG: begin
          timeout_count_next = '0;
        end
        MSG_NAK: begin
          if (link_state == ST_RUN) begin
            link_state_next    = ST_WLOGIN;
            send               = SEND_LOGIN;
            retry_count_next   = '0;
            timeout_count_next = '0;
          end else begin
            link_state_next  = ST_DISC;
            retry_count_next = '0;
          end
        end
        MSG_CLOSE: begin
          link_state_next  = ST_DISC;
          retry_count_next = '0;
        end
        MSG_DATA: begin
          if (link_state == ST_WOPTIONS) begin
            link_state_next    = ST_RUN;
            timeout_count_next = '0;
            ping_count_next    = '0;
          end
          deliver = (link_state == ST_WOPTIONS) || (link_state == ST_RUN);
        end
        default: ;
      endcase
    end
  end

  // Link state register
  always_ff @(posedge clk) begin
    if (rst) begin
      link_state <= ST_DISC;
    end else if (advance) begin
      link_state <= link_state_next;
    end
  end

  // Counters and salt
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_count   <= '0;
      timeout_count <= '0;
      ping_count    <= '0;
      salt_store    <= '0;
    end else if (advance) begin
      retry_count   <= retry_count_next;
      timeout_count <= timeout_count_next;
      ping_count    <= ping_count_next;
      salt_store    <= salt_store_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= advance || (res_valid && res_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.send_code    <= send;
      res.deliver_data <= deliver;
      res.link_state   <= link_state_next;
      res.salt_out     <= salt_store_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rll_checker.sv =====
`default_nettype none

module rll_checker
  import rll_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      res_valid,
  input wire logic      res_stall,
  input wire res_item_t res
);

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled res item changed");

  // Data is only passed on with the link running
  a_deliver_run: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.deliver_data |-> res.link_state == ST_RUN)
    else $error("data delivered while link not running");

  // Options are sent only toward the options wait or on a timeout drop
  a_options_state: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.send_code == SEND_OPTIONS |->
      res.link_state == ST_WOPTIONS || res.link_state == ST_DISC)
    else $error("options sent in wrong link state");

  // Nothing leaves the block right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("res item valid after reset");

endmodule

bind repeater_login_link_fsm rll_checker u_rll_checker (.*);

`default_nettype wire
